// ----- rtl/mbe_pkg.sv -----
// mbe_pkg: shared types and constants of the escape-time block.
// Used by mbe_mul, mbe_seq and mandelbrot_escape_time_top. No dependencies.
package mbe_pkg;

  // fixed-point word
  localparam int unsigned FX_W = 64;
  localparam logic [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam logic [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  // stream field widths
  localparam int unsigned PIXEL_W = 12;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned ZOOM_W  = 63;

  // configuration register indexes
  localparam logic [2:0] REG_ZOOM_STEP  = 3'd0;
  localparam logic [2:0] REG_CENTER_RE  = 3'd1;
  localparam logic [2:0] REG_CENTER_IM  = 3'd2;
  localparam logic [2:0] REG_MAX_ITER   = 3'd3;
  localparam logic [2:0] REG_IMG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_IMG_HEIGHT = 3'd5;

  // right shift applied to a product
  typedef enum logic [1:0] {
    SH_ONE,
    SH_FRAC,
    SH_FRAC_M1
  } shift_sel_e;

  // request to the shared multiplier
  typedef struct packed {
    logic            start;
    logic [FX_W-1:0] a;
    logic [FX_W-1:0] b;
    shift_sel_e      sh;
  } mul_req_t;

  // multiplier response, done is a one-cycle pulse
  typedef struct packed {
    logic            done;
    logic [FX_W-1:0] res;
  } mul_rsp_t;

  // configuration register file contents
  typedef struct packed {
    logic [ZOOM_W-1:0]  zoom;
    logic [FX_W-1:0]    center_re;
    logic [FX_W-1:0]    center_im;
    logic [COUNT_W-1:0] max_iter;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

endpackage

// ----- rtl/mbe_mul.sv -----
// mbe_mul: shared 64x64 signed fixed-point multiplier, one 32x32 partial product per cycle.
// Floors the shifted product and saturates to 64 bits. Depends on mbe_pkg.
module mbe_mul #(
  parameter int unsigned FRAC_BITS = 58
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbe_pkg::mul_req_t req_i,
  output mbe_pkg::mul_rsp_t rsp_o
);

  localparam int unsigned SHV_ONE  = 1;
  localparam int unsigned SHV_F    = FRAC_BITS;
  localparam int unsigned SHV_F1   = FRAC_BITS - 1;
  localparam int unsigned W        = mbe_pkg::FX_W;
  localparam int unsigned HW       = W / 2;

  // step codes
  localparam logic [2:0] ST_PP0   = 3'd0;
  localparam logic [2:0] ST_PP1   = 3'd1;
  localparam logic [2:0] ST_PP2   = 3'd2;
  localparam logic [2:0] ST_PP3   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_SHIFT = 3'd5;
  localparam logic [2:0] ST_ROUND = 3'd6;

  logic                busy_q, busy_d;
  logic [2:0]          step_q, step_d;
  logic                done_q, done_d;
  logic [W-1:0]        ua_q, ub_q;
  logic                neg_q;
  mbe_pkg::shift_sel_e sh_q;
  logic [W-1:0]        p_q;
  logic [2*W-1:0]      acc_q;
  logic [W-1:0]        q_q;
  logic                over_q, rem_q;
  logic [W-1:0]        res_q;

  logic [HW-1:0]       a_half, b_half;
  logic [W-1:0]        prod;
  logic [2:0]          pstep;
  logic [2*W-1:0]      p_shift, acc_sum, prod_sh;
  logic                rem_d;
  logic [W-1:0]        res_d;
  logic                big_neg;

  // partial product of the current step
  assign a_half = step_q[1] ? ua_q[W-1:HW] : ua_q[HW-1:0];
  assign b_half = step_q[0] ? ub_q[W-1:HW] : ub_q[HW-1:0];
  assign prod   = {{HW{1'b0}}, a_half} * {{HW{1'b0}}, b_half};

  // align the product registered one step earlier
  assign pstep = step_q - 3'd1;
  always_comb begin
    case (pstep)
      ST_PP0:         p_shift = {{W{1'b0}}, p_q};
      ST_PP1, ST_PP2: p_shift = {{HW{1'b0}}, p_q, {HW{1'b0}}};
      ST_PP3:         p_shift = {p_q, {W{1'b0}}};
      default:        p_shift = '0;
    endcase
  end
  assign acc_sum = acc_q + p_shift;

  // fraction shift and sticky remainder
  always_comb begin
    case (sh_q)
      mbe_pkg::SH_ONE: begin
        prod_sh = acc_q >> SHV_ONE;
        rem_d   = |acc_q[SHV_ONE-1:0];
      end
      mbe_pkg::SH_FRAC: begin
        prod_sh = acc_q >> SHV_F;
        rem_d   = |acc_q[SHV_F-1:0];
      end
      mbe_pkg::SH_FRAC_M1: begin
        prod_sh = acc_q >> SHV_F1;
        rem_d   = |acc_q[SHV_F1-1:0];
      end
      default: begin
        prod_sh = '0;
        rem_d   = 1'b0;
      end
    endcase
  end

  // sign, floor rounding and saturation
  assign big_neg = over_q | q_q[W-1] | ((&q_q[W-2:0]) & rem_q);
  always_comb begin
    if (!neg_q) begin
      res_d = (over_q || q_q[W-1]) ? mbe_pkg::FX_MAX : q_q;
    end else begin
      res_d = big_neg ? mbe_pkg::FX_MIN : (~q_q + {{(W-1){1'b0}}, ~rem_q});
    end
  end

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = busy_q && (step_q == ST_ROUND);
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = ST_PP0;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      if (step_q == ST_ROUND) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= ST_PP0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ua_q  <= req_i.a[W-1] ? (~req_i.a + {{(W-1){1'b0}}, 1'b1}) : req_i.a;
      ub_q  <= req_i.b[W-1] ? (~req_i.b + {{(W-1){1'b0}}, 1'b1}) : req_i.b;
      neg_q <= req_i.a[W-1] ^ req_i.b[W-1];
      sh_q  <= req_i.sh;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q <= ST_PP3) p_q <= prod;
      if (step_q >= ST_PP1 && step_q <= ST_ACC) acc_q <= acc_sum;
      if (step_q == ST_SHIFT) begin
        q_q    <= prod_sh[W-1:0];
        over_q <= |prod_sh[2*W-1:W];
        rem_q  <= rem_d;
      end
      if (step_q == ST_ROUND) res_q <= res_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ----- rtl/mbe_seq.sv -----
// mbe_seq: per-pixel sequencer; maps the pixel to c and runs the z = z^2 + c loop.
// Issues every product to the shared mbe_mul. Depends on mbe_pkg.
module mbe_seq #(
  parameter int unsigned FRAC_BITS  = 58,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mbe_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  input  logic [mbe_pkg::PIXEL_W-1:0]    pixel_x_i,
  input  logic [mbe_pkg::PIXEL_W-1:0]    pixel_y_i,
  output logic                           in_ready_o,
  output mbe_pkg::mul_req_t              mul_req_o,
  input  mbe_pkg::mul_rsp_t              mul_rsp_i,
  output logic                           res_valid_o,
  output logic [mbe_pkg::COUNT_W-1:0]    res_count_o,
  input  logic                           res_take_i
);

  localparam int unsigned W  = mbe_pkg::FX_W;
  localparam int unsigned CW = (COORD_BITS < mbe_pkg::PIXEL_W) ? COORD_BITS : mbe_pkg::PIXEL_W;
  localparam int unsigned KW = 15;
  localparam logic signed [W-1:0] LIMIT = 64'sd4 <<< FRAC_BITS;

  // states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CR   = 3'd1;
  localparam logic [2:0] S_CI   = 3'd2;
  localparam logic [2:0] S_NEXT = 3'd3;
  localparam logic [2:0] S_R2   = 3'd4;
  localparam logic [2:0] S_I2   = 3'd5;
  localparam logic [2:0] S_XZ   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? mbe_pkg::FX_MIN : mbe_pkg::FX_MAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? mbe_pkg::FX_MIN : mbe_pkg::FX_MAX;
    return s[W-1:0];
  endfunction

  logic [2:0]                  state_q, state_d;
  logic [CW-1:0]               py_q, py_d;
  logic [mbe_pkg::COUNT_W-1:0] n_q, n_d, count_q, count_d;
  logic [W-1:0]                cr_q, cr_d, ci_q, ci_d, zr_q, zr_d, zi_q, zi_d;
  logic [W-1:0]                r2_q, r2_d, diff_q, diff_d;

  logic [CW-1:0]               coord_x;
  logic signed [KW-1:0]        kx, ky;
  logic [W-1:0]                sum_ri, ci_new;
  logic                        escape;
  logic [mbe_pkg::COUNT_W-1:0] last_n;

  // centering offsets 2*coord - dim
  assign coord_x = pixel_x_i[CW-1:0];
  assign kx = $signed(KW'({coord_x, 1'b0})) - $signed(KW'(cfg_i.width));
  assign ky = $signed(KW'({py_q, 1'b0})) - $signed(KW'(cfg_i.height));

  // escape test on the old |z|^2
  assign sum_ri = sat_add(r2_q, mul_rsp_i.res);
  assign escape = $signed(sum_ri) > LIMIT;
  assign ci_new = sat_add(cfg_i.center_im, mul_rsp_i.res);
  assign last_n = cfg_i.max_iter - 16'd1;

  always_comb begin
    state_d = state_q;
    py_d    = py_q;
    n_d     = n_q;
    count_d = count_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    r2_d    = r2_q;
    diff_d  = diff_q;
    mul_req_o.start = 1'b0;
    mul_req_o.a     = zr_q;
    mul_req_o.b     = zr_q;
    mul_req_o.sh    = mbe_pkg::SH_FRAC;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          py_d            = pixel_y_i[CW-1:0];
          mul_req_o.start = 1'b1;
          mul_req_o.a     = {{(W-KW){kx[KW-1]}}, kx};
          mul_req_o.b     = {1'b0, cfg_i.zoom};
          mul_req_o.sh    = mbe_pkg::SH_ONE;
          state_d         = S_CR;
        end
      end
      S_CR: begin
        if (mul_rsp_i.done) begin
          cr_d            = sat_add(cfg_i.center_re, mul_rsp_i.res);
          mul_req_o.start = 1'b1;
          mul_req_o.a     = {{(W-KW){ky[KW-1]}}, ky};
          mul_req_o.b     = {1'b0, cfg_i.zoom};
          mul_req_o.sh    = mbe_pkg::SH_ONE;
          state_d         = S_CI;
        end
      end
      S_CI: begin
        if (mul_rsp_i.done) begin
          ci_d = ci_new;
          zr_d = cr_q;
          zi_d = ci_new;
          n_d  = '0;
          if (cfg_i.max_iter == '0) begin
            count_d = last_n;
            state_d = S_DONE;
          end else begin
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        mul_req_o.start = 1'b1;
        state_d         = S_R2;
      end
      S_R2: begin
        if (mul_rsp_i.done) begin
          r2_d            = mul_rsp_i.res;
          mul_req_o.start = 1'b1;
          mul_req_o.a     = zi_q;
          mul_req_o.b     = zi_q;
          state_d         = S_I2;
        end
      end
      S_I2: begin
        if (mul_rsp_i.done) begin
          diff_d = sat_sub(r2_q, mul_rsp_i.res);
          if (escape) begin
            count_d = n_q;
            state_d = S_DONE;
          end else begin
            mul_req_o.start = 1'b1;
            mul_req_o.a     = zr_q;
            mul_req_o.b     = zi_q;
            mul_req_o.sh    = mbe_pkg::SH_FRAC_M1;
            state_d         = S_XZ;
          end
        end
      end
      S_XZ: begin
        if (mul_rsp_i.done) begin
          zi_d = sat_add(mul_rsp_i.res, ci_q);
          zr_d = sat_add(diff_q, cr_q);
          if (n_q == last_n) begin
            count_d = last_n;
            state_d = S_DONE;
          end else begin
            n_d     = n_q + 16'd1;
            state_d = S_NEXT;
          end
        end
      end
      S_DONE: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    py_q    <= py_d;
    n_q     <= n_d;
    count_q <= count_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    r2_q    <= r2_d;
    diff_q  <= diff_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_count_o = count_q;

endmodule

// ----- rtl/mandelbrot_escape_time_top.sv -----
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  pixel coordinate
// m_axis    out  m_axis_tvalid / m_axis_tready  escape count
// cfg       in   cfg_we_i (no wait)             register write
//
// Pixel time is set by the shared 32x32 multiplier, which works through its partial products,
// accumulation, shift and rounding for each product of the mapping and for each of the
// three products of an iteration. The block takes one pixel at a time.
// The result sits in an output register, so a new pixel is taken while it waits.
// Reset clears the control state and loads the register reset values.
//
// mandelbrot_escape_time_top: configuration registers, stream ports and output register.
// Depends on mbe_pkg, mbe_mul and mbe_seq.
module mandelbrot_escape_time_top #(
  parameter int unsigned FRAC_BITS  = 58,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] escape_count
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  mbe_pkg::cfg_t     cfg_q, cfg_d;
  mbe_pkg::mul_req_t mul_req;
  mbe_pkg::mul_rsp_t mul_rsp;
  logic              res_valid, res_take;
  logic [15:0]       res_count;
  logic              out_valid_q, out_valid_d;
  logic [15:0]       out_data_q;

  // configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mbe_pkg::REG_ZOOM_STEP:  cfg_d.zoom      = cfg_wdata_i[62:0];
        mbe_pkg::REG_CENTER_RE:  cfg_d.center_re = cfg_wdata_i;
        mbe_pkg::REG_CENTER_IM:  cfg_d.center_im = cfg_wdata_i;
        mbe_pkg::REG_MAX_ITER:   cfg_d.max_iter  = cfg_wdata_i[15:0];
        mbe_pkg::REG_IMG_WIDTH:  cfg_d.width     = cfg_wdata_i[12:0];
        mbe_pkg::REG_IMG_HEIGHT: cfg_d.height    = cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom      <= '0;
      cfg_q.center_re <= '0;
      cfg_q.center_im <= '0;
      cfg_q.max_iter  <= 16'd256;
      cfg_q.width     <= 13'd1024;
      cfg_q.height    <= 13'd1024;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mbe_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  mbe_seq #(
    .FRAC_BITS (FRAC_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .pixel_x_i  (s_axis_tdata[11:0]),
    .pixel_y_i  (s_axis_tdata[23:12]),
    .in_ready_o (s_axis_tready),
    .mul_req_o  (mul_req),
    .mul_rsp_i  (mul_rsp),
    .res_valid_o(res_valid),
    .res_count_o(res_count),
    .res_take_i (res_take)
  );

  // output register, loads whenever it is free or being drained
  assign res_take = res_valid && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_data_q <= res_count;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a pending result never coexists with input ready
  a_busy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid && s_axis_tready))
    else $error("input ready while a result is pending");

  // an accepted transaction drops ready on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready stayed high after an input transaction");

  // a result handed over shows on the output next cycle
  a_take_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> (m_axis_tvalid && (m_axis_tdata == $past(res_count))))
    else $error("result lost between sequencer and output register");

  // a result not handed over stays pending
  a_hold_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_take) |=> (res_valid && $stable(res_count)))
    else $error("pending result dropped");

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for mandelbrot_escape_time_top: drives pixel coordinates,
// predicts each escape count in fixed point and compares it with the output stream.
// Depends on mbe_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

  localparam int FRAC  = 58;
  localparam int COORD = 12;

  localparam int RANDOM_PIXELS    = 900;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 8;
  localparam int DRAIN_CYCLES     = 60;
  localparam int MAX_PRINTED      = 100;
  localparam longint TIMEOUT_NS   = 40_000_000;

  typedef logic signed [63:0]  fx_t;
  typedef logic signed [129:0] fx_wide_t;

  // indexes with no register behind them
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;

  typedef struct packed {
    logic [11:0] y;
    logic [11:0] x;
  } pixel_t;

  localparam fx_t ESCAPE_LIMIT = fx_t'(64'd4 << FRAC);
  localparam fx_t ONE_MILLI    = fx_t'((64'd1 << FRAC) / 1000);

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [11:0] pixel_x, [23:12] pixel_y
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] escape_count
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [63:0] cfg_wdata_i   = '0;

  // mirror of the register file, starts at the reset values
  mbe_pkg::cfg_t view = '{zoom: '0, center_re: '0, center_im: '0, max_iter: 16'd256,
                          width: 13'd1024, height: 13'd1024};

  pixel_t      pixels_pending[$];
  logic [15:0] escape_counts_due[$];

  int errors         = 0;
  int pixels_queued  = 0;
  int pixels_sent    = 0;
  int results_seen   = 0;
  int escaped_early  = 0;
  int settings_used  = 1;
  int hold_requests  = 0;
  int hold_served    = 0;
  bit no_idle        = 1'b0;

  int feed_gap   = 0;
  int drain_wait = 0;

  mandelbrot_escape_time_top #(
    .FRAC_BITS (FRAC),
    .COORD_BITS(COORD)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------- fixed-point predictor ----------------

  function automatic fx_t fx_sat(input fx_wide_t v);
    if (v > $signed({66'd0, mbe_pkg::FX_MAX})) return mbe_pkg::FX_MAX;
    if (v < $signed({{66{1'b1}}, mbe_pkg::FX_MIN})) return mbe_pkg::FX_MIN;
    return v[63:0];
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    fx_wide_t s;
    s = a;
    s = s + b;
    return fx_sat(s);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    fx_wide_t s;
    s = a;
    s = s - b;
    return fx_sat(s);
  endfunction

  // exact product, floor shift, saturate
  function automatic fx_t fx_mul_floor(input fx_t a, input fx_t b, input int sh);
    fx_wide_t wa, wb, p;
    wa = a;
    wb = b;
    p  = (wa * wb) >>> sh;
    return fx_sat(p);
  endfunction

  // c = center + floor((2*coord - dim) * zoom / 2)
  function automatic fx_t plane_point(input fx_t center, input logic [12:0] dim,
                                      input logic [11:0] coord);
    fx_t k;
    k = $signed({51'd0, coord, 1'b0}) - $signed({51'd0, dim});
    return fx_add(center, fx_mul_floor(k, fx_t'({1'b0, view.zoom}), 1));
  endfunction

  function automatic logic [15:0] escape_count_of(input logic [11:0] px,
                                                  input logic [11:0] py);
    logic [11:0] cmask;
    fx_t cr, ci, zr, zi, r2, i2, xprod;
    int n;
    cmask = 12'((1 << COORD) - 1);
    cr = plane_point(view.center_re, view.width, px & cmask);
    ci = plane_point(view.center_im, view.height, py & cmask);
    zr = cr;
    zi = ci;
    for (n = 0; n < int'(view.max_iter); n++) begin
      r2    = fx_mul_floor(zr, zr, FRAC);
      i2    = fx_mul_floor(zi, zi, FRAC);
      xprod = fx_mul_floor(zr, zi, FRAC - 1);
      zi    = fx_add(xprod, ci);
      zr    = fx_add(fx_sub(r2, i2), cr);
      if (fx_add(r2, i2) > ESCAPE_LIMIT) return n[15:0];
    end
    return view.max_iter - 16'd1;
  endfunction

  task automatic flag_mismatch(input string what);
    if (errors < MAX_PRINTED) $display("%0t ns  MISMATCH  %s", $time, what);
    errors++;
  endtask

  // ---------------- pixel driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] due_n;
    int          gap_n;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      feed_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_n = escape_count_of(s_axis_tdata[11:0], s_axis_tdata[23:12]);
        escape_counts_due.push_back(due_n);
        if (due_n != view.max_iter - 16'd1) escaped_early++;
        pixels_sent++;
        gap_n = no_idle ? 0 : $urandom_range(0, 9);
      end else begin
        gap_n = (feed_gap > 0) ? feed_gap - 1 : 0;
      end
      // a pixel still waiting for tready keeps its place
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_n == 0 && pixels_pending.size() != 0) begin
          s_axis_tdata  <= pixels_pending.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      feed_gap <= gap_n;
    end
  end

  // ---------------- result monitor ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] due;
    int          next_wait;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      drain_wait    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (escape_counts_due.size() == 0) begin
          flag_mismatch($sformatf("escape count %0d with no pixel outstanding",
                                  m_axis_tdata));
        end else begin
          due = escape_counts_due.pop_front();
          results_seen++;
          if (m_axis_tdata !== due)
            flag_mismatch($sformatf("escape_count got %0d expected %0d (result %0d)",
                                    m_axis_tdata, due, results_seen));
        end
      end
      next_wait = drain_wait;
      if (hold_served != hold_requests) begin
        // long back-pressure so the block fills and stalls its input
        next_wait = LONG_HOLD_CYCLES;
        hold_served <= hold_served + 1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        next_wait = no_idle ? 0 : $urandom_range(0, 9);
      end else if (next_wait > 0) begin
        next_wait--;
      end
      drain_wait    <= next_wait;
      m_axis_tready <= (next_wait == 0);
    end
  end

  // ---------------- stimulus ----------------

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mbe_pkg::REG_ZOOM_STEP:  view.zoom      = value[62:0];
      mbe_pkg::REG_CENTER_RE:  view.center_re = value;
      mbe_pkg::REG_CENTER_IM:  view.center_im = value;
      mbe_pkg::REG_MAX_ITER:   view.max_iter  = value[15:0];
      mbe_pkg::REG_IMG_WIDTH:  view.width     = value[12:0];
      mbe_pkg::REG_IMG_HEIGHT: view.height    = value[12:0];
      default: ;
    endcase
  endtask

  // wait until every queued pixel has come back, then let the block settle
  task automatic wait_drained();
    while (results_seen < pixels_queued)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_pixel(input int x, input int y);
    pixel_t p;
    p.x = 12'(x);
    p.y = 12'(y);
    pixels_pending.push_back(p);
    pixels_queued++;
  endtask

  initial begin
    int w, h, n_items, k, queued;
    bit framed;
    logic [63:0] word;

    repeat (4) @(posedge clk_i);
    rst_ni  <= 1'b1;
    no_idle <= 1'b1;

    // reset values: zero pitch and center, 256 iterations, never escapes
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(4095, 0);
    push_pixel(0, 4095);
    wait_drained();

    // zero limit wraps to all ones; spare indexes must not disturb anything
    no_idle <= 1'b0;
    write_reg(mbe_pkg::REG_MAX_ITER, 64'd0);
    write_reg(REG_SPARE6, 64'hDEAD_BEEF_0000_0001);
    write_reg(REG_SPARE7, 64'hFFFF_FFFF_FFFF_FFFF);
    settings_used++;
    push_pixel(1, 2);
    push_pixel(4095, 0);
    wait_drained();

    // saturated point, dropped upper bits, zero width, single iteration
    write_reg(mbe_pkg::REG_ZOOM_STEP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(mbe_pkg::REG_CENTER_RE, mbe_pkg::FX_MAX);
    write_reg(mbe_pkg::REG_CENTER_IM, mbe_pkg::FX_MIN);
    write_reg(mbe_pkg::REG_IMG_WIDTH, 64'd0);
    write_reg(mbe_pkg::REG_IMG_HEIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(mbe_pkg::REG_MAX_ITER, 64'h0000_0000_0001_0001);
    settings_used++;
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(2048, 100);
    wait_drained();

    // largest limit with instant escape, odd dimensions, long output stall
    write_reg(mbe_pkg::REG_ZOOM_STEP, 64'd1 << 40);
    write_reg(mbe_pkg::REG_CENTER_RE, 64'd3 << FRAC);
    write_reg(mbe_pkg::REG_CENTER_IM, 64'd0);
    write_reg(mbe_pkg::REG_IMG_WIDTH, 64'd1);
    write_reg(mbe_pkg::REG_IMG_HEIGHT, 64'd4095);
    write_reg(mbe_pkg::REG_MAX_ITER, 64'hFFFF);
    settings_used++;
    no_idle       <= 1'b1;
    hold_requests <= hold_requests + 1;
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(0, 4095);
    push_pixel(4095, 0);
    push_pixel(2730, 1365);
    push_pixel(1365, 2730);
    wait_drained();

    // classic view around -0.5, some points stay bounded
    no_idle <= 1'b0;
    write_reg(mbe_pkg::REG_ZOOM_STEP, (64'd3 << FRAC) / 8);
    write_reg(mbe_pkg::REG_CENTER_RE, -(64'sd1 <<< (FRAC - 1)));
    write_reg(mbe_pkg::REG_CENTER_IM, 64'd0);
    write_reg(mbe_pkg::REG_MAX_ITER, 64'd48);
    write_reg(mbe_pkg::REG_IMG_WIDTH, 64'd8);
    write_reg(mbe_pkg::REG_IMG_HEIGHT, 64'd7);
    settings_used++;
    push_pixel(0, 0);
    push_pixel(4, 3);
    push_pixel(7, 6);
    push_pixel(2, 5);
    push_pixel(5, 1);
    push_pixel(3, 3);
    push_pixel(1, 4);
    push_pixel(6, 2);
    wait_drained();

    // random settings, each followed by a batch of pixels
    queued = 0;
    while (queued < RANDOM_PIXELS) begin
      framed = ($urandom_range(0, 4) < 3);
      if (framed) begin
        w    = $urandom_range(2, 48);
        h    = $urandom_range(2, 48);
        word = ((64'd3 << FRAC) / (w * 100)) * $urandom_range(50, 150);
        write_reg(mbe_pkg::REG_ZOOM_STEP, word);
        write_reg(mbe_pkg::REG_CENTER_RE,
                  fx_t'(int'($urandom_range(0, 2500)) - 2000) * ONE_MILLI);
        write_reg(mbe_pkg::REG_CENTER_IM,
                  fx_t'(int'($urandom_range(0, 3000)) - 1500) * ONE_MILLI);
        write_reg(mbe_pkg::REG_MAX_ITER, 64'($urandom_range(1, 32)));
        write_reg(mbe_pkg::REG_IMG_WIDTH, 64'(w));
        write_reg(mbe_pkg::REG_IMG_HEIGHT, 64'(h));
      end else begin
        w = 4096;
        h = 4096;
        write_reg(mbe_pkg::REG_ZOOM_STEP, {$urandom, $urandom} >> $urandom_range(0, 63));
        if ($urandom_range(0, 1))
          write_reg(mbe_pkg::REG_CENTER_RE, {$urandom, $urandom});
        else
          write_reg(mbe_pkg::REG_CENTER_RE,
                    fx_t'(int'($urandom_range(0, 4000)) - 2000) * ONE_MILLI);
        if ($urandom_range(0, 1))
          write_reg(mbe_pkg::REG_CENTER_IM, {$urandom, $urandom});
        else
          write_reg(mbe_pkg::REG_CENTER_IM,
                    fx_t'(int'($urandom_range(0, 4000)) - 2000) * ONE_MILLI);
        write_reg(mbe_pkg::REG_MAX_ITER, {$urandom, 16'h0, 16'($urandom_range(0, 24))});
        write_reg(mbe_pkg::REG_IMG_WIDTH, 64'($urandom_range(0, 8191)));
        write_reg(mbe_pkg::REG_IMG_HEIGHT, 64'($urandom_range(0, 8191)));
      end
      if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE6, {$urandom, $urandom});
      settings_used++;
      no_idle <= ($urandom_range(0, 4) == 0);
      if (settings_used == 8) hold_requests <= hold_requests + 1;

      n_items = $urandom_range(30, 80);
      for (k = 0; k < n_items; k++) begin
        if (framed && $urandom_range(0, 7) != 0)
          push_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
        else
          push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
      queued += n_items;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (escape_counts_due.size() != 0)
      flag_mismatch($sformatf("%0d escape counts never arrived", escape_counts_due.size()));

    $display("Run covered %0d pixels over %0d register settings, %0d results compared.",
             pixels_sent, settings_used, results_seen);
    $display("%0d pixels escaped before the limit, %0d mismatches.", escaped_early, errors);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout after %0d pixels and %0d results.", pixels_sent, results_seen);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
